// ===== hdl/str_pkg.sv =====
// ============================================================================
// str_pkg: shared types and constants for the sequence-tagged result ring
// Beat formats for the command and result channels, operation codes and
// default sizing.
// ============================================================================
package str_pkg;

	localparam int SEQ_W         = 31;
	localparam int SLOT_W        = 3;
	localparam int OP_W          = 2;
	localparam int SLOTS_DEFAULT = 8;

	localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
	localparam logic [OP_W-1:0] OP_COMMIT  = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [SEQ_W-1:0] sequence_req;
		logic             want_latest;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              found;
	} res_t;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic done;
		res_t res;
	} seq_rsp_t;

endpackage

// ===== hdl/str_ram.sv =====
// ============================================================================
// str_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module str_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/str_seq.sv =====
// ============================================================================
// str_seq: ring state and lookup sequencer
// Holds the newest pointer, the slot valid bits and the tag RAM, applies
// acquire and commit, and walks the ring through one shared comparator.
// ============================================================================
module str_seq #(
	parameter int SLOTS = str_pkg::SLOTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  str_pkg::cmd_t     cmd,
	input  logic              take,
	output logic              busy,
	output str_pkg::seq_rsp_t rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]                  state_q;
	logic [IDX_W-1:0]            newest_q;
	logic                        any_q;
	logic [SLOTS-1:0]            valid_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            cnt_q;
	logic [str_pkg::SEQ_W-1:0]   seq_q;
	str_pkg::res_t               res_q;

	logic [IDX_W-1:0]            next_idx;
	logic [IDX_W-1:0]            prev_idx;
	logic                        ram_we;
	logic [str_pkg::SEQ_W-1:0]   rd_tag;
	logic                        hit;

	// Before the first commit the newest pointer sits just ahead of slot 0.
	always_comb begin
		if (!any_q || newest_q == LAST) begin
			next_idx = '0;
		end else begin
			next_idx = newest_q + IDX_W'(1);
		end
		if (idx_q == '0) begin
			prev_idx = LAST;
		end else begin
			prev_idx = idx_q - IDX_W'(1);
		end
	end

	assign ram_we = (state_q == S_IDLE) && start && (cmd.operation == str_pkg::OP_COMMIT);
	assign hit    = valid_q[idx_q] && (seq_q >= rd_tag);

	str_ram #(
		.WIDTH(str_pkg::SEQ_W),
		.DEPTH(SLOTS)
	) u_tags (
		.clk  (clk),
		.we   (ram_we),
		.waddr(next_idx),
		.wdata(cmd.sequence_req),
		.raddr(idx_q),
		.rdata(rd_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			newest_q <= '0;
			any_q    <= 1'b0;
			valid_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (cmd.operation)
							str_pkg::OP_ACQUIRE: begin
								valid_q[next_idx] <= 1'b0;
								state_q           <= S_DONE;
							end
							str_pkg::OP_COMMIT: begin
								valid_q[next_idx] <= 1'b1;
								newest_q          <= next_idx;
								any_q             <= 1'b1;
								state_q           <= S_DONE;
							end
							str_pkg::OP_LOOKUP: begin
								state_q <= cmd.want_latest ? S_DONE : S_READ;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit || cnt_q == LAST) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Walk bookkeeping and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					seq_q <= cmd.sequence_req;
					cnt_q <= '0;
					idx_q <= any_q ? newest_q : LAST;
					case (cmd.operation)
						str_pkg::OP_ACQUIRE, str_pkg::OP_COMMIT: begin
							res_q.slot  <= str_pkg::SLOT_W'(next_idx);
							res_q.found <= 1'b1;
						end
						str_pkg::OP_LOOKUP: begin
							res_q.slot  <= any_q ? str_pkg::SLOT_W'(newest_q) : '0;
							res_q.found <= cmd.want_latest;
						end
						default: begin
							res_q.slot  <= '0;
							res_q.found <= 1'b0;
						end
					endcase
				end
			end
			S_CMP: begin
				if (hit) begin
					res_q.slot  <= str_pkg::SLOT_W'(idx_q);
					res_q.found <= 1'b1;
				end else begin
					res_q.slot  <= '0;
					res_q.found <= 1'b0;
					idx_q       <= prev_idx;
					cnt_q       <= cnt_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy     = (state_q != S_IDLE);
	assign rsp.done = (state_q == S_DONE);
	assign rsp.res  = res_q;

endmodule

// ===== hdl/sequence_tagged_result_ring.sv =====
// ============================================================================
// sequence_tagged_result_ring: frame-sequence tagged ring of result slots
// Top level: command intake, sequencer and registered result output.
// ============================================================================
// Each command beat produces exactly one result beat. Acquire, commit, latest
// lookup and the unused code go from acceptance to the done state and then to
// the output register; a sequence lookup walks the ring from the newest slot
// toward the oldest, through a read and a compare state per slot examined, up
// to SLOTS slots. The walk is paced by the single read port of the tag RAM and
// the one comparator shared across all slots. The block takes one command at
// a time and holds cmd_stall high until its result has moved into the output
// register, which then waits for the consumer on its own.
module sequence_tagged_result_ring #(
	parameter int SLOTS = str_pkg::SLOTS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  str_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output str_pkg::res_t res
);

	logic              busy;
	logic              out_free;
	str_pkg::seq_rsp_t seq_rsp;
	logic              res_valid_q;
	str_pkg::res_t     res_q;

	assign cmd_stall = busy;
	assign out_free  = !res_valid_q || !res_stall;

	str_seq #(
		.SLOTS(SLOTS)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd_valid && !busy),
		.cmd   (cmd),
		.take  (out_free),
		.busy  (busy),
		.rsp   (seq_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= seq_rsp.done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && seq_rsp.done) begin
			res_q <= seq_rsp.res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// An accepted command keeps the intake closed on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command intake open right after an accepted beat");

	// A finished result waits in the sequencer while the output is occupied.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		seq_rsp.done && !out_free |=> seq_rsp.done && $stable(seq_rsp.res))
		else $error("pending result lost while output register was full");

	// A miss always reports slot zero.
	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.slot == '0)
		else $error("miss reported with a nonzero slot");

endmodule

// ===== tb/sequence_tagged_result_ring_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sequence_tagged_result_ring_tb: self-checking bench for the result ring
// Drives a table of directed commands, then random camera-frame sequences of
// acquire, commit and lookup beats with random gaps and result stalls. Each
// accepted command is run through a local model of the ring; every result
// beat is checked against the oldest outstanding expected result.
// ============================================================================
module sequence_tagged_result_ring_tb;

	localparam int SLOTS        = str_pkg::SLOTS_DEFAULT;
	localparam int TOTAL_ITEMS  = 1675;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 10;

	localparam logic [str_pkg::OP_W-1:0]  OP_UNUSED = 2'd3;
	localparam logic [str_pkg::SEQ_W-1:0] SEQ_MAX   = '1;

	typedef struct {
		logic [str_pkg::OP_W-1:0]   op;
		logic [str_pkg::SEQ_W-1:0]  seq;
		logic                       latest;
		bit                         typed;
		logic [str_pkg::SLOT_W-1:0] slot;
		logic                       found;
	} stim_row_t;

	logic           clk;
	logic           arst_n;
	logic           cmd_valid;
	logic           cmd_stall;
	str_pkg::cmd_t  cmd;
	logic           res_valid;
	logic           res_stall;
	str_pkg::res_t  res;

	// Local copy of the ring state, advanced once per accepted command beat.
	logic [str_pkg::SEQ_W-1:0] ring_tag [SLOTS];
	bit                        ring_valid [SLOTS];
	int                        ring_newest;
	bit                        ring_any;

	str_pkg::res_t expected_results [$];
	stim_row_t     directed_rows [$];
	int            error_count;
	int            items_sent;
	int            quiet_left;
	logic [str_pkg::SEQ_W-1:0] frame_seq;

	sequence_tagged_result_ring #(
		.SLOTS(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic str_pkg::res_t predict_ring(input str_pkg::cmd_t c);
		str_pkg::res_t r;
		int   next;
		int   start;
		int   idx;
		r = '0;
		next = ring_any ? (ring_newest + 1) % SLOTS : 0;
		case (c.operation)
			str_pkg::OP_ACQUIRE: begin
				ring_valid[next] = 1'b0;
				r.slot = next[str_pkg::SLOT_W-1:0];
				r.found = 1'b1;
			end
			str_pkg::OP_COMMIT: begin
				ring_newest = next;
				ring_any = 1'b1;
				ring_tag[next] = c.sequence_req;
				ring_valid[next] = 1'b1;
				r.slot = next[str_pkg::SLOT_W-1:0];
				r.found = 1'b1;
			end
			str_pkg::OP_LOOKUP: begin
				if (c.want_latest) begin
					r.slot = ring_any ? ring_newest[str_pkg::SLOT_W-1:0] : '0;
					r.found = 1'b1;
				end else begin
					// Walk newest to oldest; before any commit the walk starts at the top slot.
					start = ring_any ? ring_newest : SLOTS - 1;
					for (int i = 0; i < SLOTS && !r.found; i++) begin
						idx = (start + SLOTS - i) % SLOTS;
						if (ring_valid[idx] && c.sequence_req >= ring_tag[idx]) begin
							r.slot = idx[str_pkg::SLOT_W-1:0];
							r.found = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic stim_row_t row(input logic [str_pkg::OP_W-1:0] op,
			input logic [str_pkg::SEQ_W-1:0] seq,
			input logic latest, input bit typed, input logic [str_pkg::SLOT_W-1:0] slot,
			input logic found);
		stim_row_t s;
		s.op = op;
		s.seq = seq;
		s.latest = latest;
		s.typed = typed;
		s.slot = slot;
		s.found = found;
		return s;
	endfunction

	// Lookup targets cluster around recent frames so the walk stops at varied depths.
	function automatic logic [str_pkg::SEQ_W-1:0] pick_lookup_seq();
		int r;
		int d;
		r = $urandom_range(99, 0);
		d = $urandom_range(20, 0);
		if (r < 70)
			return (frame_seq > d) ? frame_seq - str_pkg::SEQ_W'(d) : '0;
		else if (r < 80)
			return frame_seq + str_pkg::SEQ_W'(d);
		else if (r < 87)
			return '0;
		else if (r < 92)
			return SEQ_MAX;
		return str_pkg::SEQ_W'($urandom);
	endfunction

	// Presents one command beat, waits for it to be taken, then predicts its result.
	task automatic send_cmd(input logic [str_pkg::OP_W-1:0] op,
			input logic [str_pkg::SEQ_W-1:0] seq,
			input logic latest, input bit typed, input str_pkg::res_t typed_res);
		str_pkg::cmd_t c;
		str_pkg::res_t predicted;
		int   gap;
		c.operation = op;
		c.sequence_req = seq;
		c.want_latest = latest;
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predicted = predict_ring(c);
		expected_results.push_back(typed ? typed_res : predicted);
		items_sent++;
		if (quiet_left > 0) begin
			quiet_left--;
			gap = 0;
		end else begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_op(input logic [str_pkg::OP_W-1:0] op,
			input logic [str_pkg::SEQ_W-1:0] seq, input logic latest);
		send_cmd(op, seq, latest, 1'b0, '0);
	endtask

	task automatic wait_all_results();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	always @(posedge clk) begin : result_check
		str_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: result beat with none expected: slot=%0d found=%0b",
						$realtime, res.slot, res.found);
			end else begin
				want = expected_results.pop_front();
				if (res.slot !== want.slot || res.found !== want.found) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: mismatch: expected slot=%0d found=%0b, got slot=%0d found=%0b",
							$realtime, want.slot, want.found, res.slot, res.found);
				end
			end
		end
	end

	// Result side: runs of acceptance broken by stalls, with occasional long clean runs.
	initial begin : result_stall_gen
		int run_len;
		int stall_len;
		res_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run_len = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 100)
				: $urandom_range(12, 1);
			repeat (run_len) @(posedge clk);
			stall_len = pick_gap();
			if (stall_len > 0) begin
				res_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : run_limit
		#20ms;
		$display("** sequence_tagged_result_ring: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int   kind;
		int   n_lookups;
		int   next_drain_at;
		str_pkg::res_t typed_res;

		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		error_count = 0;
		items_sent = 0;
		quiet_left = 0;
		ring_newest = 0;
		ring_any = 1'b0;
		foreach (ring_valid[i])
			ring_valid[i] = 1'b0;

		// Opening rows exercise the empty ring; later rows wrap the ring once.
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  '0,      1'b1, 1, 3'd0, 1'b1));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  SEQ_MAX, 1'b0, 1, 3'd0, 1'b0));
		directed_rows.push_back(row(OP_UNUSED,           SEQ_MAX, 1'b1, 1, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_ACQUIRE, SEQ_MAX, 1'b1, 1, 3'd0, 1'b1));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  '0,      1'b1, 1, 3'd0, 1'b1));
		directed_rows.push_back(row(str_pkg::OP_COMMIT,  '0,      1'b0, 1, 3'd0, 1'b1));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  '0,      1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_COMMIT,  SEQ_MAX, 1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  SEQ_MAX - str_pkg::SEQ_W'(1),
			1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  SEQ_MAX, 1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_ACQUIRE, '0,      1'b0, 0, 3'd0, 1'b0));
		for (int s = 1000; s <= 1005; s++)
			directed_rows.push_back(row(str_pkg::OP_COMMIT, str_pkg::SEQ_W'(s), 1'b1, 0,
				3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_ACQUIRE, '0,       1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  '0,       1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_COMMIT,  31'd1006, 1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  31'd1003, 1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  '0,       1'b1, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(OP_UNUSED,           '0,       1'b0, 1, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_LOOKUP,  31'd999,  1'b0, 0, 3'd0, 1'b0));
		directed_rows.push_back(row(str_pkg::OP_ACQUIRE, SEQ_MAX,  1'b1, 0, 3'd0, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed_res.slot = directed_rows[i].slot;
			typed_res.found = directed_rows[i].found;
			send_cmd(directed_rows[i].op, directed_rows[i].seq, directed_rows[i].latest,
				directed_rows[i].typed, typed_res);
		end
		wait_all_results();

		frame_seq = str_pkg::SEQ_W'($urandom_range(5000, 0));
		next_drain_at = items_sent + 400;
		while (items_sent < TOTAL_ITEMS) begin
			if (quiet_left == 0 && $urandom_range(24, 0) == 0)
				quiet_left = $urandom_range(80, 20);
			kind = $urandom_range(99, 0);
			if (kind < 55) begin
				// A normal frame: acquire, commit, then look back at recent frames.
				send_op(str_pkg::OP_ACQUIRE, str_pkg::SEQ_W'($urandom), 1'($urandom));
				send_op(str_pkg::OP_COMMIT, frame_seq, 1'($urandom));
				frame_seq = frame_seq + str_pkg::SEQ_W'($urandom_range(3, 1));
				n_lookups = $urandom_range(2, 0);
				repeat (n_lookups)
					send_op(str_pkg::OP_LOOKUP, pick_lookup_seq(), ($urandom_range(3, 0) == 0));
			end else if (kind < 70) begin
				send_op(str_pkg::OP_LOOKUP, pick_lookup_seq(), 1'($urandom));
			end else if (kind < 80) begin
				send_op(str_pkg::OP_COMMIT,
					($urandom_range(1, 0) == 0) ? frame_seq : str_pkg::SEQ_W'($urandom),
					1'($urandom));
			end else if (kind < 88) begin
				send_op(str_pkg::OP_ACQUIRE, str_pkg::SEQ_W'($urandom), 1'($urandom));
			end else if (kind < 93) begin
				send_op(OP_UNUSED, str_pkg::SEQ_W'($urandom), 1'($urandom));
			end else if (kind < 97) begin
				// Broken frame: a lookup lands between acquire and commit.
				send_op(str_pkg::OP_ACQUIRE, str_pkg::SEQ_W'($urandom), 1'($urandom));
				send_op(str_pkg::OP_LOOKUP, pick_lookup_seq(), 1'($urandom));
				send_op(str_pkg::OP_COMMIT, frame_seq, 1'($urandom));
			end else begin
				// Sequence restart leaves older tags above the new frames.
				frame_seq = ($urandom_range(3, 0) == 0)
					? SEQ_MAX - str_pkg::SEQ_W'($urandom_range(40, 0))
					: str_pkg::SEQ_W'($urandom);
			end
			if (items_sent >= next_drain_at) begin
				wait_all_results();
				next_drain_at = items_sent + 400;
			end
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("** sequence_tagged_result_ring: PASSED **");
		else
			$display("** sequence_tagged_result_ring: FAILED **");
		$finish;
	end

endmodule
